@@ sv/forth_stack_execute_unit_macros.svh @@
// Assertion macros shared by the stack execute unit RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FORTH_STACK_EXECUTE_UNIT_MACROS_SVH
`define FORTH_STACK_EXECUTE_UNIT_MACROS_SVH

`ifndef SYNTH
// implication check: ante |-> cons
`define FSEU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle check: ante |=> cons
`define FSEU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FSEU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define FSEU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/fseu_pkg.sv @@
// Package for the stack execute unit: command, kind and error codes,
// default sizes and the controller/datapath handshake structs. No dependencies.
`default_nettype none

package fseu_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int CELL_BITS_DEF   = 64;
    localparam int MAX_RESULTS     = 64;

    localparam int CMD_W  = 5;
    localparam int VAL_W  = 64;
    localparam int IP_W   = 16;
    localparam int KIND_W = 3;
    localparam int ERR_W  = 2;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 88;

    // command codes
    localparam logic [CMD_W-1:0] CMD_RET   = 5'd0;
    localparam logic [CMD_W-1:0] CMD_BYE   = 5'd1;
    localparam logic [CMD_W-1:0] CMD_EMIT  = 5'd2;
    localparam logic [CMD_W-1:0] CMD_KEY   = 5'd3;
    localparam logic [CMD_W-1:0] CMD_PRINT = 5'd4;
    localparam logic [CMD_W-1:0] CMD_LIST  = 5'd5;
    localparam logic [CMD_W-1:0] CMD_DEPTH = 5'd6;
    localparam logic [CMD_W-1:0] CMD_ADD   = 5'd7;
    localparam logic [CMD_W-1:0] CMD_SUB   = 5'd8;
    localparam logic [CMD_W-1:0] CMD_MUL   = 5'd9;
    localparam logic [CMD_W-1:0] CMD_DIV   = 5'd10;
    localparam logic [CMD_W-1:0] CMD_MOD   = 5'd11;
    localparam logic [CMD_W-1:0] CMD_GT    = 5'd12;
    localparam logic [CMD_W-1:0] CMD_LT    = 5'd13;
    localparam logic [CMD_W-1:0] CMD_EQ    = 5'd14;
    localparam logic [CMD_W-1:0] CMD_NOT   = 5'd15;
    localparam logic [CMD_W-1:0] CMD_DUP   = 5'd16;
    localparam logic [CMD_W-1:0] CMD_OVER  = 5'd17;
    localparam logic [CMD_W-1:0] CMD_PICK  = 5'd18;
    localparam logic [CMD_W-1:0] CMD_DROP  = 5'd19;
    localparam logic [CMD_W-1:0] CMD_SWAP  = 5'd20;
    localparam logic [CMD_W-1:0] CMD_AGAIN = 5'd21;
    localparam logic [CMD_W-1:0] CMD_SKIP  = 5'd22;
    localparam logic [CMD_W-1:0] CMD_LIT   = 5'd23;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EMIT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PRINT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LIST  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HALT  = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_DIVZ  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic rd_b;
        logic rd_a;
        logic ld_b;
        logic exec;
        logic pick_rd;
        logic pick_ld;
        logic mul_step;
        logic div_step;
        logic div_fin;
        logic swap_wr;
        logic commit;
        logic list_rd;
        logic list_ld;
        logic list_next;
        logic out_load;
    } t_dp_ctrl;

    // datapath to controller
    typedef struct packed {
        logic err;
        logic op_pick;
        logic op_mul;
        logic op_div;
        logic op_swap;
        logic op_list;
        logic list_empty;
        logic list_last;
        logic unit_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ sv/fseu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module fseu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/fseu_datapath.sv @@
// Datapath of the stack execute unit: item registers, stack RAM, depth,
// decode, ALU, shared multiplier, bit-serial divider and output register.
// Depends on fseu_pkg, fseu_ram and the assertion macro header.
`default_nettype none
`include "forth_stack_execute_unit_macros.svh"

module fseu_datapath #(
    parameter int STACK_DEPTH = fseu_pkg::STACK_DEPTH_DEF,
    parameter int CELL_BITS   = fseu_pkg::CELL_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  fseu_pkg::t_dp_ctrl            i_ctrl,
    output fseu_pkg::t_dp_status          o_status,
    input  wire [fseu_pkg::S_DATA_W-1:0]  i_s_tdata,
    input  wire [fseu_pkg::CMD_W-1:0]     i_s_tuser,
    input  wire                           i_m_tready,
    output logic                          o_m_tvalid,
    output logic [fseu_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic [fseu_pkg::KIND_W-1:0]   o_m_tuser,
    output logic                          o_m_tlast
);

    import fseu_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int LIST_MAX = (STACK_DEPTH < MAX_RESULTS) ? STACK_DEPTH : MAX_RESULTS;

    function automatic logic [VAL_W-1:0] f_mag(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (VAL_W'(0) - v) : v;
    endfunction

    // item registers
    logic [CMD_W-1:0]  r_cmd;
    logic [VAL_W-1:0]  r_opv;
    logic [IP_W-1:0]   r_ip;
    logic [IP_W-1:0]   r_ra;
    // stack state and operands
    logic [DW-1:0]     r_depth;
    logic [VAL_W-1:0]  r_a;
    logic [VAL_W-1:0]  r_b;
    logic [VAL_W-1:0]  r_res;
    // decoded plan
    logic [ERR_W-1:0]  r_err;
    logic [KIND_W-1:0] r_kind;
    logic [IP_W-1:0]   r_nip;
    logic              r_we;
    logic [AW-1:0]     r_waddr;
    logic [DW-1:0]     r_dnext;
    // units
    logic [6:0]        r_cnt;
    logic [VAL_W-1:0]  r_quo;
    logic [VAL_W-1:0]  r_rem;
    logic [VAL_W-1:0]  r_dvs;
    logic [AW-1:0]     r_idx;
    // output register
    logic              r_ovalid;
    logic [KIND_W-1:0] r_okind;
    logic [VAL_W-1:0]  r_oval;
    logic [IP_W-1:0]   r_onip;
    logic [ERR_W-1:0]  r_oerr;
    logic              r_olast;

    logic [CELL_BITS-1:0] ram_rdata;
    logic [VAL_W-1:0]     rd_ext;
    logic [VAL_W-1:0]     w_a;
    logic [AW-1:0]        ram_raddr;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [CELL_BITS-1:0] ram_wdata;
    logic [DW-1:0]        w_dm1;
    logic [DW-1:0]        w_dm2;
    logic [DW-1:0]        w_dp1;
    logic [DW-1:0]        w_cnt;
    logic                 d_lt1;
    logic                 d_lt2;
    logic                 d_full;
    logic                 list_last;
    logic [ERR_W-1:0]     dec_err;
    logic [KIND_W-1:0]    dec_kind;
    logic [IP_W-1:0]      dec_nip;
    logic                 dec_we;
    logic [AW-1:0]        dec_waddr;
    logic [DW-1:0]        dec_dnext;
    logic [VAL_W-1:0]     dec_res;
    logic [31:0]          mul_x;
    logic [31:0]          mul_y;
    logic [63:0]          mul_p;
    logic [VAL_W-1:0]     div_sh;
    logic                 div_ge;

    assign rd_ext = VAL_W'($signed(ram_rdata));
    assign w_a    = i_ctrl.exec ? rd_ext : r_a;
    assign w_dm1  = r_depth - DW'(1);
    assign w_dm2  = r_depth - DW'(2);
    assign w_dp1  = r_depth + DW'(1);
    assign d_lt1  = (r_depth == '0);
    assign d_lt2  = (r_depth < DW'(2));
    assign d_full = (r_depth >= DW'(STACK_DEPTH));
    assign w_cnt  = (r_depth < DW'(LIST_MAX)) ? r_depth : DW'(LIST_MAX);
    assign list_last = (DW'(r_idx) == w_cnt - DW'(1));

    // stack memory
    fseu_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // read address select
    always_comb begin
        if (i_ctrl.rd_b) begin
            ram_raddr = w_dm1[AW-1:0];
        end else if (i_ctrl.rd_a) begin
            ram_raddr = w_dm2[AW-1:0];
        end else if (i_ctrl.pick_rd) begin
            ram_raddr = w_dm2[AW-1:0] - r_b[AW-1:0];
        end else if (i_ctrl.list_rd) begin
            ram_raddr = r_idx;
        end else begin
            ram_raddr = w_dm1[AW-1:0];
        end
    end

    // write port: swap writes the lower cell first, commit writes the planned cell
    assign ram_we    = (i_ctrl.commit && r_we) || i_ctrl.swap_wr;
    assign ram_waddr = i_ctrl.swap_wr ? w_dm2[AW-1:0] : r_waddr;
    assign ram_wdata = i_ctrl.swap_wr ? r_b[CELL_BITS-1:0] : r_res[CELL_BITS-1:0];

    // word decode: error, kind, next ip, write plan and simple ALU result
    always_comb begin
        dec_err   = ERR_NONE;
        dec_kind  = KIND_NONE;
        dec_nip   = r_ip;
        dec_we    = 1'b0;
        dec_waddr = r_depth[AW-1:0];
        dec_dnext = r_depth;
        dec_res   = '0;
        unique case (r_cmd) inside
            CMD_RET: begin
                dec_nip = r_ra;
            end
            CMD_BYE: begin
                dec_kind = KIND_HALT;
            end
            CMD_EMIT, CMD_PRINT: begin
                if (d_lt1) begin
                    dec_err = ERR_UNDER;
                end else begin
                    dec_dnext = w_dm1;
                    dec_kind  = (r_cmd == CMD_EMIT) ? KIND_EMIT : KIND_PRINT;
                    dec_res   = (r_cmd == CMD_EMIT) ? {56'd0, r_b[7:0]} : r_b;
                end
            end
            CMD_KEY, CMD_DEPTH, CMD_LIT: begin
                if (d_full) begin
                    dec_err = ERR_OVER;
                end else begin
                    dec_we    = 1'b1;
                    dec_dnext = w_dp1;
                    dec_res   = (r_cmd == CMD_DEPTH) ? VAL_W'(r_depth) : r_opv;
                end
            end
            CMD_LIST: begin
                dec_kind = d_lt1 ? KIND_NONE : KIND_LIST;
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_GT, CMD_LT, CMD_EQ: begin
                if (d_lt2) begin
                    dec_err = ERR_UNDER;
                end else if ((r_cmd == CMD_DIV || r_cmd == CMD_MOD) && r_b == '0) begin
                    dec_err = ERR_DIVZ;
                end else begin
                    dec_we    = 1'b1;
                    dec_waddr = w_dm2[AW-1:0];
                    dec_dnext = w_dm1;
                    case (r_cmd)
                        CMD_ADD: dec_res = w_a + r_b;
                        CMD_SUB: dec_res = w_a - r_b;
                        CMD_GT:  dec_res = VAL_W'($signed(r_b) < $signed(w_a));
                        CMD_LT:  dec_res = VAL_W'($signed(w_a) < $signed(r_b));
                        CMD_EQ:  dec_res = VAL_W'(w_a == r_b);
                        default: dec_res = '0;
                    endcase
                end
            end
            CMD_NOT: begin
                if (d_lt1) begin
                    dec_err = ERR_UNDER;
                end else begin
                    dec_we    = 1'b1;
                    dec_waddr = w_dm1[AW-1:0];
                    dec_res   = (r_b == '0) ? '1 : '0;
                end
            end
            CMD_DUP, CMD_OVER: begin
                if (d_lt1 || (r_cmd == CMD_OVER && d_lt2)) begin
                    dec_err = ERR_UNDER;
                end else if (d_full) begin
                    dec_err = ERR_OVER;
                end else begin
                    dec_we    = 1'b1;
                    dec_dnext = w_dp1;
                    dec_res   = (r_cmd == CMD_DUP) ? r_b : w_a;
                end
            end
            CMD_PICK: begin
                if (d_lt1 || r_b[VAL_W-1] || (r_b >= VAL_W'(w_dm1))) begin
                    dec_err = ERR_UNDER;
                end else begin
                    dec_we    = 1'b1;
                    dec_waddr = w_dm1[AW-1:0];
                end
            end
            CMD_DROP: begin
                if (d_lt1) begin
                    dec_err = ERR_UNDER;
                end else begin
                    dec_dnext = w_dm1;
                end
            end
            CMD_SWAP: begin
                if (d_lt2) begin
                    dec_err = ERR_UNDER;
                end else begin
                    dec_we    = 1'b1;
                    dec_waddr = w_dm1[AW-1:0];
                    dec_res   = w_a;
                end
            end
            CMD_AGAIN, CMD_SKIP: begin
                if (d_lt1) begin
                    dec_err = ERR_UNDER;
                end else begin
                    dec_dnext = w_dm1;
                    if (r_b != '0) begin
                        dec_nip = (r_cmd == CMD_AGAIN) ? (r_ip - IP_W'(2)) : (r_ip + IP_W'(1));
                    end
                end
            end
            default: begin
                dec_kind = KIND_NONE;
            end
        endcase
    end

    // shared 32x32 multiplier: low product, then the two cross terms
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin mul_x = r_a[31:0];  mul_y = r_b[31:0];  end
            2'd1:    begin mul_x = r_a[31:0];  mul_y = r_b[63:32]; end
            default: begin mul_x = r_a[63:32]; mul_y = r_b[31:0];  end
        endcase
    end
    assign mul_p = 64'(mul_x) * 64'(mul_y);

    // restoring divider step
    assign div_sh = {r_rem[VAL_W-2:0], r_quo[VAL_W-1]};
    assign div_ge = (div_sh >= r_dvs);

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_cmd <= i_s_tuser;
            r_opv <= i_s_tdata[63:0];
            r_ip  <= i_s_tdata[79:64];
            r_ra  <= i_s_tdata[95:80];
        end
    end

    // operands, plan, units and list index
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_b) begin
            r_b <= rd_ext;
        end
        if (i_ctrl.exec) begin
            r_a     <= w_a;
            r_err   <= dec_err;
            r_kind  <= dec_kind;
            r_nip   <= dec_nip;
            r_we    <= dec_we;
            r_waddr <= dec_waddr;
            r_dnext <= dec_dnext;
            r_res   <= dec_res;
            r_cnt   <= '0;
            r_quo   <= f_mag(w_a);
            r_rem   <= '0;
            r_dvs   <= f_mag(r_b);
            r_idx   <= '0;
        end
        if (i_ctrl.pick_ld || i_ctrl.list_ld) begin
            r_res <= rd_ext;
        end
        if (i_ctrl.list_next) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_ctrl.mul_step) begin
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt == 7'd0) begin
                r_res <= mul_p;
            end else begin
                r_res <= r_res + {mul_p[31:0], 32'd0};
            end
        end
        if (i_ctrl.div_step) begin
            r_cnt <= r_cnt + 7'd1;
            r_rem <= div_ge ? (div_sh - r_dvs) : div_sh;
            r_quo <= {r_quo[VAL_W-2:0], div_ge};
        end
        if (i_ctrl.div_fin) begin
            if (r_cmd == CMD_DIV) begin
                r_res <= (r_a[VAL_W-1] ^ r_b[VAL_W-1]) ? (VAL_W'(0) - r_quo) : r_quo;
            end else begin
                r_res <= r_a[VAL_W-1] ? (VAL_W'(0) - r_rem) : r_rem;
            end
        end
    end

    // stack depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_ctrl.commit) begin
            r_depth <= r_dnext;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_okind <= r_kind;
            r_oval  <= (r_kind == KIND_EMIT || r_kind == KIND_PRINT || r_kind == KIND_LIST)
                       ? r_res : '0;
            r_onip  <= r_nip;
            r_oerr  <= r_err;
            r_olast <= (r_kind != KIND_LIST) || list_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_oerr, r_onip, r_oval};
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

    // status to controller
    assign o_status.err        = (dec_err != ERR_NONE);
    assign o_status.op_pick    = (r_cmd == CMD_PICK);
    assign o_status.op_mul     = (r_cmd == CMD_MUL);
    assign o_status.op_div     = (r_cmd == CMD_DIV) || (r_cmd == CMD_MOD);
    assign o_status.op_swap    = (r_cmd == CMD_SWAP);
    assign o_status.op_list    = (r_cmd == CMD_LIST);
    assign o_status.list_empty = d_lt1;
    assign o_status.list_last  = list_last;
    assign o_status.unit_done  = (r_cmd == CMD_MUL) ? (r_cnt == 7'd3) : (r_cnt == 7'd64);
    assign o_status.out_free   = !r_ovalid || i_m_tready;

    // checks
    `FSEU_ASSERT_IMP(a_depth_range, i_clk, i_rst_n, 1'b1, r_depth <= DW'(STACK_DEPTH), "stack depth beyond capacity")
    `FSEU_ASSERT_IMP(a_out_no_overwrite, i_clk, i_rst_n, r_ovalid && !i_m_tready, !i_ctrl.out_load, "pending result overwritten")
    `FSEU_ASSERT_NXT(a_depth_commit_only, i_clk, i_rst_n, !i_ctrl.commit, r_depth == $past(r_depth), "depth changed outside commit")

endmodule

`default_nettype wire

@@ sv/fseu_ctrl.sv @@
// Controller state machine of the stack execute unit.
// Depends on fseu_pkg and the assertion macro header.
`default_nettype none
`include "forth_stack_execute_unit_macros.svh"

module fseu_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    input  fseu_pkg::t_dp_status  i_status,
    output fseu_pkg::t_dp_ctrl    o_ctrl
);

    import fseu_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_RD_B    = 13'b0000000000010,
        S_RD_A    = 13'b0000000000100,
        S_EXEC    = 13'b0000000001000,
        S_PICK_RD = 13'b0000000010000,
        S_PICK_LD = 13'b0000000100000,
        S_MUL     = 13'b0000001000000,
        S_DIV     = 13'b0000010000000,
        S_SWAP2   = 13'b0000100000000,
        S_COMMIT  = 13'b0001000000000,
        S_OUT     = 13'b0010000000000,
        S_LIST_RD = 13'b0100000000000,
        S_LIST_LD = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_ctrl.load_in = 1'b1;
                    n_state = S_RD_B;
                end
            end
            S_RD_B: begin
                o_ctrl.rd_b = 1'b1;
                n_state = S_RD_A;
            end
            S_RD_A: begin
                o_ctrl.rd_a = 1'b1;
                o_ctrl.ld_b = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_ctrl.exec = 1'b1;
                if (i_status.err) begin
                    n_state = S_COMMIT;
                end else if (i_status.op_pick) begin
                    n_state = S_PICK_RD;
                end else if (i_status.op_mul) begin
                    n_state = S_MUL;
                end else if (i_status.op_div) begin
                    n_state = S_DIV;
                end else if (i_status.op_swap) begin
                    n_state = S_SWAP2;
                end else if (i_status.op_list) begin
                    n_state = i_status.list_empty ? S_OUT : S_LIST_RD;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_PICK_RD: begin
                o_ctrl.pick_rd = 1'b1;
                n_state = S_PICK_LD;
            end
            S_PICK_LD: begin
                o_ctrl.pick_ld = 1'b1;
                n_state = S_COMMIT;
            end
            S_MUL: begin
                if (i_status.unit_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_ctrl.mul_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_status.unit_done) begin
                    o_ctrl.div_fin = 1'b1;
                    n_state = S_COMMIT;
                end else begin
                    o_ctrl.div_step = 1'b1;
                end
            end
            S_SWAP2: begin
                o_ctrl.swap_wr = 1'b1;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_ctrl.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    if (i_status.op_list && !i_status.list_empty && !i_status.list_last) begin
                        o_ctrl.list_next = 1'b1;
                        n_state = S_LIST_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LIST_RD: begin
                o_ctrl.list_rd = 1'b1;
                n_state = S_LIST_LD;
            end
            S_LIST_LD: begin
                o_ctrl.list_ld = 1'b1;
                n_state = S_OUT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // checks
    `FSEU_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state == S_RD_B, "accepted transaction did not start")
    `FSEU_ASSERT_NXT(a_out_waits, i_clk, i_rst_n, r_state == S_OUT && !i_status.out_free, r_state == S_OUT, "left output state while blocked")

endmodule

`default_nettype wire

@@ sv/forth_stack_execute_unit.sv @@
// Ordinary words read the operands, execute, commit, then present the result;
// the next item is taken once back in idle. Pick adds a read and load, swap a
// second write, mul three passes through one 32x32 multiplier, div and mod one
// quotient bit a cycle. Stack listing sends each cell subject to back-pressure.
// Synchronous active-low reset empties the stack; cell contents are not cleared.
// Top level of the stack execute unit: controller plus datapath.
// Depends on fseu_pkg, fseu_ctrl, fseu_datapath.
`default_nettype none

module forth_stack_execute_unit #(
    parameter int STACK_DEPTH = fseu_pkg::STACK_DEPTH_DEF,
    parameter int CELL_BITS   = fseu_pkg::CELL_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_tvalid,
    output logic                          o_s_tready,
    // [63:0] operand_value, [79:64] ip_value, [95:80] return_address
    input  wire [fseu_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [4:0] command
    input  wire [fseu_pkg::CMD_W-1:0]     i_s_tuser,
    output logic                          o_m_tvalid,
    input  wire                           i_m_tready,
    // [63:0] value, [79:64] next_ip, [81:80] error, [87:82] zero
    output logic [fseu_pkg::M_DATA_W-1:0] o_m_tdata,
    // [2:0] kind
    output logic [fseu_pkg::KIND_W-1:0]   o_m_tuser,
    output logic                          o_m_tlast
);

    import fseu_pkg::*;

    t_dp_ctrl   ctrl;
    t_dp_status status;

    fseu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    fseu_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .CELL_BITS   (CELL_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .o_status   (status),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
